FILE: rtl/rgbc3_pkg.sv
package rgbc3_pkg;

    localparam int LINE_DEPTH  = 4096;
    localparam int COL_W       = $clog2(LINE_DEPTH);
    localparam int COUNT_W     = 12;
    localparam int GEOM_W      = 13;
    localparam int CH_W        = 8;
    localparam int CFG_W       = 13;
    localparam int SUM_W       = 14;

    localparam logic [GEOM_W-1:0] COUNT_LIMIT  = 13'd4096;
    localparam logic [GEOM_W-1:0] WIDTH_LIMIT  =
        (LINE_DEPTH < 4096) ? GEOM_W'(LINE_DEPTH) : COUNT_LIMIT;

    // register indexes of the configuration port
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_MAXC   = 2'd3;

    // kernel select codes, the unused code acts as blur
    localparam logic [1:0] MODE_BLUR    = 2'd0;
    localparam logic [1:0] MODE_SHARPEN = 2'd1;
    localparam logic [1:0] MODE_EMBOSS  = 2'd2;
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    // 1/9 as a 16-bit fraction, exact for sums up to 9 * 255
    localparam logic [12:0] RECIP_NINE = 13'd7282;

    typedef logic [2:0][CH_W-1:0] pix_t;   // [0] red, [1] green, [2] blue

    typedef struct packed {
        logic [COUNT_W-1:0] row;
        logic [COUNT_W-1:0] col;
        pix_t               pix;
        logic               last;
    } res_t;

endpackage

FILE: rtl/rgbc3_pix_if.sv
interface rgbc3_pix_if;
    import rgbc3_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    output ready);
endinterface

FILE: rtl/rgbc3_res_if.sv
interface rgbc3_res_if;
    import rgbc3_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] out_row;
    logic [COUNT_W-1:0] out_col;
    logic [CH_W-1:0]    out_red;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_blue;
    logic               last_of_run;

    modport source (output valid, output out_row, output out_col, output out_red,
                    output out_green, output out_blue, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_row, input out_col, input out_red,
                    input out_green, input out_blue, input last_of_run,
                    output ready);
endinterface

FILE: rtl/rgbc3_kernel.sv
module rgbc3_kernel
    import rgbc3_pkg::*;
(
    input  pix_t [8:0]      taps,
    input  logic [1:0]      mode,
    input  logic [CH_W-1:0] max_color,
    output pix_t            filt
);

    // row-major, top row first; spare code repeats blur
    localparam logic signed [4:0] KERN [4][9] = '{
        '{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1, 5'sd1,  5'sd1,  5'sd1,  5'sd1},
        '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
        '{-5'sd2, -5'sd1,  5'sd0, -5'sd1,  5'sd1, 5'sd1,  5'sd0,  5'sd1,  5'sd2},
        '{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1, 5'sd1,  5'sd1,  5'sd1,  5'sd1}
    };

    logic                    is_blur;
    logic signed [SUM_W-1:0] sum_v;
    logic [24:0]             prod;
    logic signed [SUM_W-1:0] quot;

    assign is_blur = (mode == MODE_BLUR) || (mode == MODE_SPARE);

    always_comb
    begin
        filt  = '0;
        sum_v = '0;
        prod  = '0;
        quot  = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_v = '0;
            for (int k = 0; k < 9; k++)
            begin
                sum_v = sum_v + SUM_W'(KERN[mode][k] *
                                       $signed({{(SUM_W-CH_W){1'b0}}, taps[k][ch]}));
            end
            // blur sums are never negative, so the floor is the truncation
            prod = 25'(sum_v[11:0]) * 25'(RECIP_NINE);
            quot = is_blur ? $signed({5'b0, prod[24:16]}) : sum_v;
            if (quot < 0)
                filt[ch] = '0;
            else if (quot > $signed({{(SUM_W-CH_W){1'b0}}, max_color}))
                filt[ch] = max_color;
            else
                filt[ch] = quot[CH_W-1:0];
        end
    end

endmodule

FILE: rtl/rgb_conv3x3_filter.sv
// channel  dir  word                                       handshake
// pix      in   in_red, in_green, in_blue                  valid / ready
// res      out  out_row, out_col, out_red/green/blue,      valid / ready
//               last_of_run
// cfg      in   cfg_index, cfg_wdata                       cfg_we, no wait
//
// one pixel per cycle while the result register has room: input register
// plus line store read, then one pass through the 3x3 kernel into a
// two-entry result register. a pixel that causes two results holds the
// input side until the first of them is taken by the single result port.
// an accepted pixel passes the input register, then the result register.
// rst_n clears counters, window, configuration and handshake state; the line
// store is not cleared, entries are always written before they are used.
module rgb_conv3x3_filter
    import rgbc3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    rgbc3_pix_if.sink         pix,
    rgbc3_res_if.source       res,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    logic [1:0]         mode_reg;
    logic [GEOM_W-1:0]  width_reg;
    logic [GEOM_W-1:0]  height_reg;
    logic [CH_W-1:0]    maxc_reg;

    logic [COUNT_W-1:0] row_reg;
    logic [COUNT_W-1:0] col_reg;

    logic               a_valid_reg;
    pix_t               a_pix_reg;
    logic [COUNT_W-1:0] a_row_reg;
    logic [COUNT_W-1:0] a_col_reg;
    logic               a_int_reg;
    logic               a_bord_reg;
    logic [47:0]        rd_reg;

    logic [47:0]        line_mem [LINE_DEPTH];

    pix_t               win_reg [3][3];

    res_t               slot0_reg;
    res_t               slot1_reg;
    logic [1:0]         out_cnt_reg;

    logic [GEOM_W-1:0]  w_eff;
    logic [GEOM_W-1:0]  h_eff;
    logic               c_last;
    logic               r_last;
    logic [COUNT_W-1:0] row_next;
    logic [COUNT_W-1:0] col_next;
    logic               in_acc;
    logic               out_acc;
    logic               out_free;
    logic               a_go;
    pix_t               new_col [3];
    pix_t [8:0]         taps;
    pix_t               filt;
    res_t               int_res;
    res_t               bord_res;

    // effective geometry
    always_comb
    begin
        if (width_reg == '0)
            w_eff = GEOM_W'(1);
        else if (width_reg > WIDTH_LIMIT)
            w_eff = WIDTH_LIMIT;
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = GEOM_W'(1);
        else if (height_reg > COUNT_LIMIT)
            h_eff = COUNT_LIMIT;
        else
            h_eff = height_reg;
    end

    assign c_last = ({1'b0, col_reg} + 13'd1) >= w_eff;
    assign r_last = ({1'b0, row_reg} + 13'd1) >= h_eff;

    always_comb
    begin
        col_next = col_reg + 12'd1;
        row_next = row_reg;
        if (c_last)
        begin
            col_next = '0;
            row_next = r_last ? '0 : row_reg + 12'd1;
        end
    end

    assign out_acc   = res.valid && res.ready;
    assign out_free  = (out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && res.ready);
    assign a_go      = a_valid_reg && out_free;
    assign pix.ready = !a_valid_reg || a_go;
    assign in_acc    = pix.valid && pix.ready;

    // configuration and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_BLUR;
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            maxc_reg   <= 8'd255;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:   mode_reg <= cfg_wdata[1:0];
                REG_WIDTH:
                begin
                    width_reg <= cfg_wdata[GEOM_W-1:0];
                    row_reg   <= '0;
                    col_reg   <= '0;
                end
                REG_HEIGHT:
                begin
                    height_reg <= cfg_wdata[GEOM_W-1:0];
                    row_reg    <= '0;
                    col_reg    <= '0;
                end
                REG_MAXC:   maxc_reg <= cfg_wdata[CH_W-1:0];
                default:    mode_reg <= mode_reg;
            endcase
        end
        else if (in_acc)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (in_acc)
            a_valid_reg <= 1'b1;
        else if (a_go)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_pix_reg  <= {pix.in_blue, pix.in_green, pix.in_red};
            a_row_reg  <= row_reg;
            a_col_reg  <= col_reg;
            a_int_reg  <= (row_reg >= 12'd2) && (col_reg >= 12'd2);
            a_bord_reg <= (row_reg == '0) || r_last || (col_reg == '0) || c_last;
        end
    end

    // line store: upper row in the high half, middle row in the low half
    always_ff @(posedge clk)
    begin
        if (in_acc)
            rd_reg <= line_mem[col_reg[COL_W-1:0]];
        if (a_go)
            line_mem[a_col_reg[COL_W-1:0]] <= {rd_reg[23:0], a_pix_reg};
    end

    assign new_col[0] = rd_reg[47:24];
    assign new_col[1] = rd_reg[23:0];
    assign new_col[2] = a_pix_reg;

    // taps of the window as it stands after this word shifts in
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            taps[i*3]   = win_reg[i][1];
            taps[i*3+1] = win_reg[i][2];
            taps[i*3+2] = new_col[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= '0;
        end
        else if (a_go)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
                win_reg[i][2] <= new_col[i];
            end
        end
    end

    rgbc3_kernel u_kernel (
        .taps      (taps),
        .mode      (mode_reg),
        .max_color (maxc_reg),
        .filt      (filt)
    );

    assign int_res  = '{row: a_row_reg - 12'd1, col: a_col_reg - 12'd1,
                        pix: filt, last: !a_bord_reg};
    assign bord_res = '{row: a_row_reg, col: a_col_reg, pix: a_pix_reg, last: 1'b1};

    // result register, interior word ahead of the border word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_cnt_reg <= 2'd0;
        else if (a_go)
            out_cnt_reg <= {1'b0, a_int_reg} + {1'b0, a_bord_reg};
        else if (out_acc)
            out_cnt_reg <= out_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (a_go)
        begin
            slot0_reg <= a_int_reg ? int_res : bord_res;
            slot1_reg <= bord_res;
        end
        else if (out_acc)
            slot0_reg <= slot1_reg;
    end

    assign res.valid       = out_cnt_reg != 2'd0;
    assign res.out_row     = slot0_reg.row;
    assign res.out_col     = slot0_reg.col;
    assign res.out_red     = slot0_reg.pix[0];
    assign res.out_green   = slot0_reg.pix[1];
    assign res.out_blue    = slot0_reg.pix[2];
    assign res.last_of_run = slot0_reg.last;

    // a word that is not the last of its pixel always has its partner queued
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.last_of_run |-> out_cnt_reg == 2'd2)
        else $error("non-final word without a queued partner");

    // an interior result sits one row and one column behind its pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        a_go && a_int_reg |=> res.valid && res.out_row == $past(a_row_reg) - 12'd1
                              && res.out_col == $past(a_col_reg) - 12'd1)
        else $error("interior result at wrong position");

    // a pixel that causes nothing leaves the result register empty
    assert property (@(posedge clk) disable iff (!rst_n)
        a_go && !a_int_reg && !a_bord_reg |=> !res.valid)
        else $error("result invented for a silent pixel");

    // geometry writes restart the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)
        |=> row_reg == '0 && col_reg == '0)
        else $error("frame not restarted after geometry write");

endmodule

FILE: sim/rgb_conv3x3_filter_tb.sv
`timescale 1ns / 1ps

module rgb_conv3x3_filter_tb;
    import rgbc3_pkg::*;

    localparam int LONG_STALL     = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 360;
    localparam int MAX_REPORTS    = 10;
    localparam int STALL_BACKLOG  = 32;

    logic             clk = 1'b0;
    logic             rst_n = 1'b1;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    rgbc3_pix_if pix_ch ();
    rgbc3_res_if res_ch ();

    rgb_conv3x3_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // filter state as seen from outside
    pix_t              upper_row [LINE_DEPTH];
    pix_t              middle_row [LINE_DEPTH];
    pix_t              window_px [3][3];
    int                cur_row;
    int                cur_col;
    logic [1:0]        kernel_sel;
    logic [GEOM_W-1:0] width_reg;
    logic [GEOM_W-1:0] height_reg;
    logic [CH_W-1:0]   clamp_max;

    pix_t pix_pending [$];
    res_t expected_pixels [$];
    pix_t pix_on_bus;
    int   pixels_queued = 0;
    int   pixels_sent = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   quiet_cycles = 0;
    int   feed_gap;
    int   feed_calm;
    int   hold_left;
    int   hold_calm;
    bit   long_done = 1'b0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int tap(int i, int j, int ch);
        return int'(window_px[i][j][ch]);
    endfunction

    task automatic reset_filter_state();
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                window_px[i][j] = '0;
        cur_row    = 0;
        cur_col    = 0;
        kernel_sel = MODE_BLUR;
        width_reg  = 13'd640;
        height_reg = 13'd480;
        clamp_max  = 8'd255;
    endtask

    task automatic apply_config(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        case (idx)
            REG_MODE:
                kernel_sel = value[1:0];
            REG_WIDTH:
            begin
                width_reg = value;
                cur_row   = 0;
                cur_col   = 0;
            end
            REG_HEIGHT:
            begin
                height_reg = value;
                cur_row    = 0;
                cur_col    = 0;
            end
            REG_MAXC:
                clamp_max = value[CH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic conv_predict(input pix_t px);
        int   w;
        int   h;
        int   q;
        int   total;
        bit   edge_px;
        res_t item;
        w = (width_reg == 0) ? 1 : int'(width_reg);
        if (w > int'(WIDTH_LIMIT))
            w = int'(WIDTH_LIMIT);
        h = (height_reg == 0) ? 1 : int'(height_reg);
        if (h > int'(COUNT_LIMIT))
            h = int'(COUNT_LIMIT);

        for (int i = 0; i < 3; i++)
        begin
            window_px[i][0] = window_px[i][1];
            window_px[i][1] = window_px[i][2];
        end
        window_px[0][2]     = upper_row[cur_col];
        window_px[1][2]     = middle_row[cur_col];
        window_px[2][2]     = px;
        upper_row[cur_col]  = middle_row[cur_col];
        middle_row[cur_col] = px;

        edge_px = cur_row == 0 || cur_row + 1 >= h || cur_col == 0 || cur_col + 1 >= w;

        // window centre lags the incoming pixel by one row and one column
        if (cur_row >= 2 && cur_col >= 2)
        begin
            item.row  = COUNT_W'(cur_row - 1);
            item.col  = COUNT_W'(cur_col - 1);
            item.last = !edge_px;
            for (int ch = 0; ch < 3; ch++)
            begin
                total = 0;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        total += tap(i, j, ch);
                case (kernel_sel)
                    MODE_SHARPEN:
                        q = 10 * tap(1, 1, ch) - total;
                    MODE_EMBOSS:
                        q = tap(1, 1, ch) + tap(1, 2, ch) + tap(2, 1, ch) + 2 * tap(2, 2, ch)
                            - 2 * tap(0, 0, ch) - tap(0, 1, ch) - tap(1, 0, ch);
                    default:
                        q = total / 9;
                endcase
                if (q < 0)
                    q = 0;
                if (q > int'(clamp_max))
                    q = int'(clamp_max);
                item.pix[ch] = CH_W'(q);
            end
            expected_pixels.push_back(item);
        end

        if (edge_px)
        begin
            item.row  = COUNT_W'(cur_row);
            item.col  = COUNT_W'(cur_col);
            item.pix  = px;
            item.last = 1'b1;
            expected_pixels.push_back(item);
        end

        if (cur_col + 1 >= w)
        begin
            cur_col = 0;
            cur_row = (cur_row + 1 >= h) ? 0 : cur_row + 1;
        end
        else
            cur_col = cur_col + 1;
    endtask

    // pixel driver, also tracks the configuration port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_ch.valid    <= 1'b0;
            pix_ch.in_red   <= '0;
            pix_ch.in_green <= '0;
            pix_ch.in_blue  <= '0;
            feed_gap  = 0;
            feed_calm = 0;
            reset_filter_state();
        end
        else
        begin
            if (cfg_we)
                apply_config(cfg_index, cfg_wdata);
            if (pix_ch.valid && pix_ch.ready)
            begin
                conv_predict(pix_on_bus);
                pixels_sent++;
            end
            if (!pix_ch.valid || pix_ch.ready)
            begin
                if (feed_gap > 0)
                begin
                    feed_gap--;
                    pix_ch.valid <= 1'b0;
                end
                else if (pix_pending.size() != 0)
                begin
                    pix_on_bus = pix_pending.pop_front();
                    pix_ch.valid    <= 1'b1;
                    pix_ch.in_red   <= pix_on_bus[0];
                    pix_ch.in_green <= pix_on_bus[1];
                    pix_ch.in_blue  <= pix_on_bus[2];
                    if (feed_calm > 0)
                        feed_calm--;
                    else
                    begin
                        feed_gap = idle_len();
                        if ($urandom_range(0, 49) == 0)
                            feed_calm = $urandom_range(20, 120);
                    end
                end
                else
                    pix_ch.valid <= 1'b0;
            end
        end
    end

    task automatic check_result();
        res_t got;
        res_t want;
        got.row    = res_ch.out_row;
        got.col    = res_ch.out_col;
        got.pix[0] = res_ch.out_red;
        got.pix[1] = res_ch.out_green;
        got.pix[2] = res_ch.out_blue;
        got.last   = res_ch.last_of_run;
        if (expected_pixels.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected word: row %0d col %0d rgb %0d %0d %0d last %0b",
                         got.row, got.col, got.pix[0], got.pix[1], got.pix[2], got.last);
        end
        else
        begin
            want = expected_pixels.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("mismatch: expected row %0d col %0d rgb %0d %0d %0d last %0b",
                             want.row, want.col, want.pix[0], want.pix[1], want.pix[2],
                             want.last);
                    $display("          got      row %0d col %0d rgb %0d %0d %0d last %0b",
                             got.row, got.col, got.pix[0], got.pix[1], got.pix[2],
                             got.last);
                end
            end
        end
    endtask

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            hold_left = 0;
            hold_calm = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                check_result();
                results_seen++;
                // long hold-off so the block backs up into its input
                if (!long_done && pix_pending.size() >= STALL_BACKLOG)
                begin
                    long_done = 1'b1;
                    hold_left = LONG_STALL;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (hold_calm > 0)
                    hold_calm--;
                else if ($urandom_range(0, 2) == 0)
                    hold_left = idle_len();
                else if ($urandom_range(0, 49) == 0)
                    hold_calm = $urandom_range(20, 120);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic pix_t rand_pixel();
        pix_t px;
        for (int ch = 0; ch < 3; ch++)
            case ($urandom_range(0, 7))
                0:       px[ch] = '0;
                1:       px[ch] = '1;
                default: px[ch] = CH_W'($urandom_range(0, 255));
            endcase
        return px;
    endfunction

    function automatic int rand_extent();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return $urandom_range(4096, 8191);
        if (pick < 3)
            return $urandom_range(0, 2);
        return $urandom_range(3, 9);
    endfunction

    function automatic int clip_extent(int v);
        if (v == 0)
            return 1;
        return (v > 4096) ? 4096 : v;
    endfunction

    function automatic int rand_clamp();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 1;
            2:       return 255;
            default: return $urandom_range(1, 255);
        endcase
    endfunction

    task automatic queue_pixel(input pix_t px);
        pix_pending.push_back(px);
        pixels_queued++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(value);
    endtask

    task automatic set_regs(input int mode, input int w, input int h, input int maxc,
                            input bit geom);
        write_reg(REG_MODE, mode);
        if (geom)
        begin
            write_reg(REG_WIDTH, w);
            write_reg(REG_HEIGHT, h);
        end
        write_reg(REG_MAXC, maxc);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // all pixels taken, all results back, then room for pixels with no result
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pixels_sent != pixels_queued || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int   mode;
        int   w;
        int   h;
        int   count;
        int   frame;
        int   random_items;
        pix_t px;

        cfg_we    = 1'b0;
        cfg_index = REG_MODE;
        cfg_wdata = '0;
        w = 3;
        h = 3;
        random_items = 0;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // spare kernel code behaves as blur, saturated white stays white
        set_regs(MODE_SPARE, 3, 3, 255, 1'b1);
        repeat (9) queue_pixel('1);
        wait_idle();

        // sharpen with zero clamp
        set_regs(MODE_SHARPEN, 3, 3, 0, 1'b1);
        for (int k = 0; k < 9; k++)
        begin
            px = '0;
            if (k == 4)
                px = '1;
            queue_pixel(px);
        end
        wait_idle();

        // zero geometry reads as one
        set_regs(MODE_EMBOSS, 0, 0, 1, 1'b1);
        repeat (2) queue_pixel(rand_pixel());
        wait_idle();

        // oversize geometry saturates
        set_regs(MODE_BLUR, 8191, 8191, 255, 1'b1);
        repeat (3) queue_pixel(rand_pixel());
        wait_idle();

        // geometry rewritten part way through a frame, then a tiny image
        set_regs(MODE_SHARPEN, 4, 4, 255, 1'b1);
        repeat (2) queue_pixel(rand_pixel());
        wait_idle();
        set_regs(MODE_SHARPEN, 2, 2, 255, 1'b1);
        repeat (2) queue_pixel(rand_pixel());
        wait_idle();

        // full frame with a deep backlog, the long hold-off lands here
        set_regs(MODE_BLUR, 8, 8, 255, 1'b1);
        repeat (64) queue_pixel(rand_pixel());
        wait_idle();

        while (random_items < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 3);
            if (random_items == 0 || $urandom_range(0, 3) != 0)
            begin
                w = rand_extent();
                h = rand_extent();
                set_regs(mode, w, h, rand_clamp(), 1'b1);
            end
            else
                set_regs(mode, w, h, rand_clamp(), 1'b0);
            frame = clip_extent(w) * clip_extent(h);
            if (frame > 100)
                count = $urandom_range(10, 60);
            else if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, frame);
            else
                count = frame * $urandom_range(1, 2);
            repeat (count) queue_pixel(rand_pixel());
            random_items += count;
            wait_idle();
        end

        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
rtl/rgbc3_pkg.sv
rtl/rgbc3_pix_if.sv
rtl/rgbc3_res_if.sv
rtl/rgbc3_kernel.sv
rtl/rgb_conv3x3_filter.sv
sim/rgb_conv3x3_filter_tb.sv
